[rtl/mjdc_pkg.sv]
// Types, constants and the cumulative month-day table shared by the MJD date converter.
package mjdc_pkg;

   // Pipeline depth from accepted word to result strobe
   localparam int unsigned PIPE_DEPTH = 8;

   // Reciprocal multiplications use a common shift
   localparam int unsigned RECIP_SHIFT = 27;

   // Lowest MJD for which the calendar formula holds
   localparam logic [15:0] MJD_MIN = 16'd15079;

   // Year quotient: floor((20*MJD - 301564) / 7305), the 365.25 form scaled by 20
   localparam logic [20:0] YR_SCALE   = 21'd20;
   localparam logic [20:0] YR_OFFSET  = 21'd301564;
   localparam logic [14:0] YR_RECIP   = 15'd18373;   // floor(2^27 / 7305)
   localparam logic [12:0] YR_DIV     = 13'd7305;

   // Whole days in the first yp years: floor(yp * 1461 / 4)
   localparam logic [10:0] QUAD_YEAR_DAYS = 11'd1461;
   localparam logic [15:0] DAY_BASE       = 16'd14956;

   // Month quotient: floor((10000*off - 1000) / 306001)
   localparam logic [13:0] MO_SCALE = 14'd10000;
   localparam logic [22:0] MO_BIAS  = 23'd1000;
   localparam logic [8:0]  MO_RECIP = 9'd438;        // floor(2^27 / 306001)
   localparam logic [18:0] MO_DIV   = 19'd306001;

   localparam logic [10:0] YEAR_BASE = 11'd1900;
   localparam logic [3:0]  MONTHS    = 4'd12;
   localparam logic [3:0]  MP_JAN    = 4'd14;
   localparam logic [3:0]  MP_FEB    = 4'd15;

   typedef struct packed {
      logic [15:0] mjd;
      logic [7:0]  hour_bcd;
      logic [7:0]  minute_bcd;
      logic [7:0]  second_bcd;
   } req_word_type;

   typedef struct packed {
      logic [10:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [7:0]  hour_out;
      logic [7:0]  minute_out;
      logic [7:0]  second_out;
      logic        date_valid;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] hour_bcd;
      logic [7:0] minute_bcd;
      logic [7:0] second_bcd;
   } bcd_type;

   // Year stage result handed to the month stage
   typedef struct packed {
      logic        date_ok;
      logic [15:0] mjd;
      logic [7:0]  yp;
      bcd_type     bcd;
   } yr_res_type;

   // Month stage result handed to the output stage
   typedef struct packed {
      logic        date_ok;
      logic [7:0]  yp;
      logic [8:0]  off;
      logic [3:0]  mp;
      bcd_type     bcd;
   } mo_res_type;

   // floor(mp * 30.6001)
   function automatic logic [8:0] month_days(input logic [3:0] mp);
      logic [8:0] days;
      case (mp)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd30;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd91;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd153;
         4'd6:    days = 9'd183;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd244;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd306;
         4'd11:   days = 9'd336;
         4'd12:   days = 9'd367;
         4'd13:   days = 9'd397;
         4'd14:   days = 9'd428;
         default: days = 9'd459;
      endcase
      return days;
   endfunction

endpackage

[rtl/mjdc_year_div.sv]
// Three-stage year quotient: scale MJD, multiply by reciprocal, correct by one.
module mjdc_year_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  mjdc_pkg::req_word_type   in_word,
   output logic                     out_valid,
   output mjdc_pkg::yr_res_type     out_res
);
   import mjdc_pkg::*;

   // stage 1
   logic         s1_valid_ff;
   logic [20:0]  s1_num_wide;
   logic [19:0]  s1_num_in, s1_num_ff;
   logic         s1_ok_in, s1_ok_ff;
   req_word_type s1_word_ff;

   // stage 2
   logic         s2_valid_ff;
   logic [34:0]  s2_prod;
   logic [7:0]   s2_quo_in, s2_quo_ff;
   logic [19:0]  s2_num_ff;
   logic         s2_ok_ff;
   req_word_type s2_word_ff;

   // stage 3
   logic         s3_valid_ff;
   logic [19:0]  s3_prod, s3_rem;
   logic [7:0]   s3_yp_in, s3_yp_ff;
   logic         s3_ok_ff;
   req_word_type s3_word_ff;

   assign s1_num_wide = 21'(in_word.mjd) * YR_SCALE - YR_OFFSET;
   assign s1_num_in   = s1_num_wide[19:0];
   assign s1_ok_in    = (in_word.mjd >= MJD_MIN);

   assign s2_prod   = 35'(s1_num_ff) * 35'(YR_RECIP);
   assign s2_quo_in = s2_prod[RECIP_SHIFT +: 8];

   // reciprocal may come out one low: add it back
   assign s3_prod  = 20'(s2_quo_ff) * 20'(YR_DIV);
   assign s3_rem   = s2_num_ff - s3_prod;
   assign s3_yp_in = s2_quo_ff + 8'(s3_rem >= 20'(YR_DIV));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_num_ff  <= s1_num_in;
      s1_ok_ff   <= s1_ok_in;
      s1_word_ff <= in_word;
      s2_quo_ff  <= s2_quo_in;
      s2_num_ff  <= s1_num_ff;
      s2_ok_ff   <= s1_ok_ff;
      s2_word_ff <= s1_word_ff;
      s3_yp_ff   <= s3_yp_in;
      s3_ok_ff   <= s2_ok_ff;
      s3_word_ff <= s2_word_ff;
   end

   assign out_valid              = s3_valid_ff;
   assign out_res.date_ok        = s3_ok_ff;
   assign out_res.mjd            = s3_word_ff.mjd;
   assign out_res.yp             = s3_yp_ff;
   assign out_res.bcd.hour_bcd   = s3_word_ff.hour_bcd;
   assign out_res.bcd.minute_bcd = s3_word_ff.minute_bcd;
   assign out_res.bcd.second_bcd = s3_word_ff.second_bcd;

endmodule

[rtl/mjdc_month_div.sv]
// Four-stage month quotient: day offset, scale, reciprocal multiply, correct by one.
module mjdc_month_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  mjdc_pkg::yr_res_type  in_res,
   output logic                  out_valid,
   output mjdc_pkg::mo_res_type  out_res
);
   import mjdc_pkg::*;

   // stage 4: day offset within the year
   logic        s4_valid_ff;
   logic [17:0] s4_ydays_prod;
   logic [16:0] s4_off_wide;
   logic [8:0]  s4_off_in, s4_off_ff;
   logic [7:0]  s4_yp_ff;
   logic        s4_ok_ff;
   bcd_type     s4_bcd_ff;

   // stage 5: scaled numerator
   logic        s5_valid_ff;
   logic [22:0] s5_num_in, s5_num_ff;
   logic [8:0]  s5_off_ff;
   logic [7:0]  s5_yp_ff;
   logic        s5_ok_ff;
   bcd_type     s5_bcd_ff;

   // stage 6: reciprocal estimate
   logic        s6_valid_ff;
   logic [31:0] s6_prod;
   logic [4:0]  s6_quo_in, s6_quo_ff;
   logic [22:0] s6_num_ff;
   logic [8:0]  s6_off_ff;
   logic [7:0]  s6_yp_ff;
   logic        s6_ok_ff;
   bcd_type     s6_bcd_ff;

   // stage 7: correction
   logic        s7_valid_ff;
   logic [23:0] s7_prod, s7_rem;
   logic [4:0]  s7_mp_wide;
   logic [3:0]  s7_mp_in, s7_mp_ff;
   logic [8:0]  s7_off_ff;
   logic [7:0]  s7_yp_ff;
   logic        s7_ok_ff;
   bcd_type     s7_bcd_ff;

   assign s4_ydays_prod = 18'(in_res.yp) * 18'(QUAD_YEAR_DAYS);
   assign s4_off_wide   = 17'(in_res.mjd) - 17'(DAY_BASE) - 17'(s4_ydays_prod[17:2]);
   assign s4_off_in     = s4_off_wide[8:0];

   assign s5_num_in = 23'(s4_off_ff) * 23'(MO_SCALE) - MO_BIAS;

   assign s6_prod   = 32'(s5_num_ff) * 32'(MO_RECIP);
   assign s6_quo_in = s6_prod[RECIP_SHIFT +: 5];

   assign s7_prod    = 24'(s6_quo_ff) * 24'(MO_DIV);
   assign s7_rem     = 24'(s6_num_ff) - s7_prod;
   assign s7_mp_wide = s6_quo_ff + 5'(s7_rem >= 24'(MO_DIV));
   assign s7_mp_in   = s7_mp_wide[3:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= in_valid;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_off_ff <= s4_off_in;
      s4_yp_ff  <= in_res.yp;
      s4_ok_ff  <= in_res.date_ok;
      s4_bcd_ff <= in_res.bcd;

      s5_num_ff <= s5_num_in;
      s5_off_ff <= s4_off_ff;
      s5_yp_ff  <= s4_yp_ff;
      s5_ok_ff  <= s4_ok_ff;
      s5_bcd_ff <= s4_bcd_ff;

      s6_quo_ff <= s6_quo_in;
      s6_num_ff <= s5_num_ff;
      s6_off_ff <= s5_off_ff;
      s6_yp_ff  <= s5_yp_ff;
      s6_ok_ff  <= s5_ok_ff;
      s6_bcd_ff <= s5_bcd_ff;

      s7_mp_ff  <= s7_mp_in;
      s7_off_ff <= s6_off_ff;
      s7_yp_ff  <= s6_yp_ff;
      s7_ok_ff  <= s6_ok_ff;
      s7_bcd_ff <= s6_bcd_ff;
   end

   assign out_valid       = s7_valid_ff;
   assign out_res.date_ok = s7_ok_ff;
   assign out_res.yp      = s7_yp_ff;
   assign out_res.off     = s7_off_ff;
   assign out_res.mp      = s7_mp_ff;
   assign out_res.bcd     = s7_bcd_ff;

endmodule

[rtl/mjdc_date_fmt.sv]
// Output stage: day of month, January/February fold, year offset, result register.
module mjdc_date_fmt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  mjdc_pkg::mo_res_type    in_res,
   output logic                    out_valid,
   output mjdc_pkg::rsp_word_type  out_word
);
   import mjdc_pkg::*;

   logic         s8_valid_ff;
   logic [8:0]   day_wide;
   logic         jan_feb;
   rsp_word_type s8_word_in, s8_word_ff;

   assign day_wide = in_res.off - month_days(in_res.mp);
   assign jan_feb  = (in_res.mp == MP_JAN) || (in_res.mp == MP_FEB);

   always_comb begin
      s8_word_in.hour_out   = in_res.bcd.hour_bcd;
      s8_word_in.minute_out = in_res.bcd.minute_bcd;
      s8_word_in.second_out = in_res.bcd.second_bcd;
      s8_word_in.date_valid = in_res.date_ok;
      if (in_res.date_ok) begin
         s8_word_in.year  = 11'(in_res.yp) + 11'(jan_feb) + YEAR_BASE;
         s8_word_in.month = in_res.mp - 4'd1 - (jan_feb ? MONTHS : 4'd0);
         s8_word_in.day   = day_wide[4:0];
      end else begin
         s8_word_in.year  = '0;
         s8_word_in.month = '0;
         s8_word_in.day   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else begin
         s8_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s8_word_ff <= s8_word_in;
   end

   assign out_valid = s8_valid_ff;
   assign out_word  = s8_word_ff;

endmodule

[rtl/mjd_utc_to_calendar_date.sv]
// Top level of the MJD/UTC time word to calendar date converter.
//
// Input: raise start with req_word (MJD plus hour, minute, second BCD bytes);
// the word is taken at every rising edge where start is high and busy is low.
// busy stays low, so a new word may be taken in every cycle.
// Output: rsp_valid strobes for one cycle with rsp_word; the receiver takes it
// at the edge that ends that cycle and cannot hold it off.
// Throughput: one word per cycle. The depth comes from two reciprocal divides
// (year by 365.25, month by 30.6001), each split into scale, multiply and
// correct stages, one day-offset stage ahead of the month divide, and one
// output register: 3 + 1 + 3 + 1 stages.
// An MJD below 15079 gives year, month and day of zero with date_valid low.
// The BCD bytes ride along unchanged and unchecked.
// Reset clears the valid bits of all stages; words in flight are dropped.
// There is no backpressure on the result side, so no stall logic exists.
module mjd_utc_to_calendar_date (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  mjdc_pkg::req_word_type  req_word,
   output logic                    rsp_valid,
   output mjdc_pkg::rsp_word_type  rsp_word
);
   import mjdc_pkg::*;

   logic       req_take;
   logic       yr_valid;
   yr_res_type yr_res;
   logic       mo_valid;
   mo_res_type mo_res;

   // Pipeline never stalls: accept every cycle
   assign busy     = 1'b0;
   assign req_take = start & ~busy;

   // Stages 1-3: year quotient
   mjdc_year_div u_year_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_take),
      .in_word   (req_word),
      .out_valid (yr_valid),
      .out_res   (yr_res)
   );

   // Stages 4-7: day offset and month quotient
   mjdc_month_div u_month_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (yr_valid),
      .in_res    (yr_res),
      .out_valid (mo_valid),
      .out_res   (mo_res)
   );

   // Stage 8: fold January/February, register the result word
   mjdc_date_fmt u_date_fmt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mo_valid),
      .in_res    (mo_res),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

endmodule

[rtl/mjdc_checker.sv]
// Port-level checks for the MJD date converter, bound to the top level.
module mjdc_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input mjdc_pkg::req_word_type  req_word,
   input logic                    rsp_valid,
   input mjdc_pkg::rsp_word_type  rsp_word
);
   import mjdc_pkg::*;

   // Every accepted word comes out exactly after the pipeline depth
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_DEPTH rsp_valid)
      else $error("accepted word produced no result");

   // No result without a matching accepted word
   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result strobe without accepted word");

   // Validity flag follows the MJD of the word it belongs to
   a_valid_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.date_valid == ($past(req_word.mjd, PIPE_DEPTH) >= MJD_MIN)))
      else $error("date_valid does not match MJD range");

   // Invalid dates read as zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.date_valid) |->
         (rsp_word.year == 11'd0 && rsp_word.month == 4'd0 && rsp_word.day == 5'd0))
      else $error("invalid date not cleared");

   // Hour and second bytes ride along with their own word
   a_bcd_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.hour_out == $past(req_word.hour_bcd, PIPE_DEPTH) &&
                     rsp_word.second_out == $past(req_word.second_bcd, PIPE_DEPTH)))
      else $error("BCD bytes out of step with date");

endmodule

bind mjd_utc_to_calendar_date mjdc_checker u_mjdc_checker (.*);
